// ===== src/jdvm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick deadband velocity mapper package
// Shared widths, configuration register codes, axis map layout and the
// control structs that pass between the lanes, the merge stage and the top.
// ----------------------------------------------------------------------------
package jdvm_pkg;

    localparam int AXIS_W       = 16;
    localparam int AXIS_FIELDS  = 6;
    localparam int NUM_AXES     = 6;
    localparam int AXIS_LIMIT   = (NUM_AXES < AXIS_FIELDS) ? NUM_AXES : AXIS_FIELDS;
    localparam int MASK_BITS    = 16;
    localparam int NUM_BUTTONS  = 16;
    localparam int BUTTON_LIMIT = (NUM_BUTTONS < MASK_BITS) ? NUM_BUTTONS : MASK_BITS;

    localparam int VEL_W        = 17;
    localparam int MAG_W        = 16;
    localparam int PROD_W       = 32;
    localparam int FRAC_SHIFT   = 15;
    localparam int AGE_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 36;
    localparam int NUM_LANES    = 3;

    localparam logic [3:0]        AXIS_OFF   = 4'hF;
    localparam logic [PROD_W:0]   ROUND_BIAS = (PROD_W + 1)'(1 << (FRAC_SHIFT - 1));
    localparam logic [AGE_W-1:0]  AGE_MAX    = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEADMAN = 3'd0,
        REG_TIMEOUT = 3'd1,
        REG_X_MAP   = 3'd2,
        REG_Y_MAP   = 3'd3,
        REG_Z_MAP   = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] gain;
        logic [14:0] deadband;
        logic        inv;
        logic [3:0]  idx;
    } axis_map_t;

    typedef logic signed [AXIS_W-1:0]    axis_t;
    typedef axis_t [AXIS_FIELDS-1:0]     axis_vec_t;
    typedef logic signed [VEL_W-1:0]     vel_t;

    typedef struct packed {
        logic is_tick;
        logic held;
    } item_ctl_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
    } lane_en_t;

    localparam axis_map_t X_MAP_RST = axis_map_t'(36'd282119360);
    localparam axis_map_t Y_MAP_RST = axis_map_t'(36'd282119361);
    localparam axis_map_t Z_MAP_RST = axis_map_t'(36'd141610178);
    localparam logic signed [4:0] DEADMAN_RST = 5'sd0;
    localparam logic [AGE_W-1:0]  TIMEOUT_RST = 16'd50;

endpackage

// ===== src/jdvm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick mapper channel interfaces
// Sample/tick request channel and velocity result channel, valid/ready.
// ----------------------------------------------------------------------------
interface jdvm_req_if;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [2:0]        axis_count;
    logic signed [15:0] axis_zero;
    logic signed [15:0] axis_one;
    logic signed [15:0] axis_two;
    logic signed [15:0] axis_three;
    logic signed [15:0] axis_four;
    logic signed [15:0] axis_five;
    logic [15:0]       button_mask;
    logic [4:0]        button_count;

    modport source (
        output valid, cmd, axis_count, axis_zero, axis_one, axis_two,
               axis_three, axis_four, axis_five, button_mask, button_count,
        input  ready
    );
    modport sink (
        input  valid, cmd, axis_count, axis_zero, axis_one, axis_two,
               axis_three, axis_four, axis_five, button_mask, button_count,
        output ready
    );
endinterface

interface jdvm_rsp_if;
    logic              valid;
    logic              ready;
    logic signed [16:0] vel_x;
    logic signed [16:0] vel_y;
    logic signed [16:0] vel_z;
    logic              stale;

    modport source (
        output valid, vel_x, vel_y, vel_z, stale,
        input  ready
    );
    modport sink (
        input  valid, vel_x, vel_y, vel_z, stale,
        output ready
    );
endinterface

// ===== src/jdvm_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick mapper component lane
// Selects the mapped axis, removes the deadband, scales by the gain and
// rounds and saturates the result into one signed velocity component.
// ----------------------------------------------------------------------------
module jdvm_lane (
    input  logic                 clk,
    input  jdvm_pkg::lane_en_t   en,
    input  jdvm_pkg::axis_vec_t  axes,
    input  logic [2:0]           axis_count,
    input  jdvm_pkg::axis_map_t  map,
    output jdvm_pkg::vel_t       vel
);
    import jdvm_pkg::*;

    logic [2:0]         limit;
    logic               present;
    axis_t              a_sel;
    logic [MAG_W-1:0]   a_mag;
    logic               below;
    logic [MAG_W-1:0]   diff_next;

    logic [MAG_W-1:0]   diff_reg;
    logic [15:0]        gain_reg;
    logic               neg_a_reg;
    logic               zero_a_reg;

    logic [PROD_W-1:0]  prod_next;
    logic [PROD_W-1:0]  prod_reg;
    logic               neg_b_reg;
    logic               zero_b_reg;

    logic [PROD_W:0]    rounded;
    logic [MAG_W-1:0]   mag_sat;
    logic [VEL_W-1:0]   mag_ext;

    assign limit   = (axis_count > 3'(AXIS_LIMIT)) ? 3'(AXIS_LIMIT) : axis_count;
    assign present = (map.idx != AXIS_OFF) && (map.idx < {1'b0, limit});

    always_comb
    begin
        a_sel = '0;
        for (int i = 0; i < AXIS_FIELDS; i++)
        begin
            if (map.idx == 4'(i))
            begin
                a_sel = axes[i];
            end
        end
    end

    assign a_mag     = a_sel[AXIS_W-1] ? (~unsigned'(a_sel) + 16'd1) : unsigned'(a_sel);
    assign below     = a_mag < {1'b0, map.deadband};
    assign diff_next = a_mag - {1'b0, map.deadband};

    // stage A: deadband removed
    always_ff @(posedge clk)
    begin
        if (en.load_a)
        begin
            diff_reg   <= diff_next;
            gain_reg   <= map.gain;
            neg_a_reg  <= a_sel[AXIS_W-1] ^ map.inv;
            zero_a_reg <= !present || below;
        end
    end

    assign prod_next = {16'b0, diff_reg} * {16'b0, gain_reg};

    // stage B: scaled
    always_ff @(posedge clk)
    begin
        if (en.load_b)
        begin
            prod_reg   <= prod_next;
            neg_b_reg  <= neg_a_reg;
            zero_b_reg <= zero_a_reg;
        end
    end

    assign rounded = ({1'b0, prod_reg} + ROUND_BIAS) >> FRAC_SHIFT;
    assign mag_sat = (rounded > (PROD_W + 1)'({MAG_W{1'b1}})) ? {MAG_W{1'b1}}
                                                              : rounded[MAG_W-1:0];
    assign mag_ext = {1'b0, mag_sat};
    assign vel     = zero_b_reg ? '0 : (neg_b_reg ? vel_t'(~mag_ext + 17'd1)
                                                  : vel_t'(mag_ext));

endmodule

// ===== src/jdvm_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick mapper merge stage
// Gates the lane results with the deadman, holds the command, tracks the
// sample age and drives the result register on each tick.
// ----------------------------------------------------------------------------
module jdvm_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   valid_b,
    input  jdvm_pkg::item_ctl_t    ctl_b,
    input  jdvm_pkg::vel_t         lane_x,
    input  jdvm_pkg::vel_t         lane_y,
    input  jdvm_pkg::vel_t         lane_z,
    input  logic [15:0]            timeout,
    input  logic                   out_ready,
    output logic                   take,
    output logic                   out_valid,
    output jdvm_pkg::vel_t         out_x,
    output jdvm_pkg::vel_t         out_y,
    output jdvm_pkg::vel_t         out_z,
    output logic                   out_stale
);
    import jdvm_pkg::*;

    vel_t               cmd_x_reg, cmd_y_reg, cmd_z_reg;
    vel_t               cmd_x_next, cmd_y_next, cmd_z_next;
    logic               seen_reg, seen_next;
    logic [AGE_W-1:0]   age_reg, age_next;
    logic               stale;
    logic               out_valid_reg, out_valid_next;
    vel_t               out_x_reg, out_y_reg, out_z_reg;
    logic               out_stale_reg;
    logic               emit;

    assign take  = valid_b && (!ctl_b.is_tick || !out_valid_reg || out_ready);
    assign emit  = take && ctl_b.is_tick;

    always_comb
    begin
        cmd_x_next = cmd_x_reg;
        cmd_y_next = cmd_y_reg;
        cmd_z_next = cmd_z_reg;
        seen_next  = seen_reg;
        age_next   = age_reg;
        stale      = 1'b0;
        if (take)
        begin
            if (!ctl_b.is_tick)
            begin
                seen_next  = 1'b1;
                age_next   = '0;
                cmd_x_next = ctl_b.held ? lane_x : '0;
                cmd_y_next = ctl_b.held ? lane_y : '0;
                cmd_z_next = ctl_b.held ? lane_z : '0;
            end
            else
            begin
                age_next = (age_reg == AGE_MAX) ? age_reg : age_reg + 16'd1;
                stale    = !seen_reg || (age_next > timeout);
                if (stale)
                begin
                    cmd_x_next = '0;
                    cmd_y_next = '0;
                    cmd_z_next = '0;
                end
            end
        end
    end

    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_x_reg     <= '0;
            cmd_y_reg     <= '0;
            cmd_z_reg     <= '0;
            seen_reg      <= 1'b0;
            age_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_x_reg     <= cmd_x_next;
            cmd_y_reg     <= cmd_y_next;
            cmd_z_reg     <= cmd_z_next;
            seen_reg      <= seen_next;
            age_reg       <= age_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result beat
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_x_reg     <= cmd_x_next;
            out_y_reg     <= cmd_y_next;
            out_z_reg     <= cmd_z_next;
            out_stale_reg <= stale;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign out_stale = out_stale_reg;

endmodule

// ===== src/joystick_deadband_velocity_mapper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick deadband velocity mapper
// A beat passes lane stages A and B; a tick then fills the result register.
// Throughput: one beat per cycle if rsp is ready; three lanes share each
// beat, a merge stage holds the command, a result register parts the channels.
// Reset: rst_n clears the command, sample age, pipeline valids and loads
// the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module joystick_deadband_velocity_mapper (
    input  logic                             clk,
    input  logic                             rst_n,
    jdvm_req_if.sink                         req,
    jdvm_rsp_if.source                       rsp,
    input  logic                             cfg_we,
    input  logic [jdvm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [jdvm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import jdvm_pkg::*;

    logic signed [4:0]  deadman_reg;
    logic [AGE_W-1:0]   timeout_reg;
    axis_map_t          map_reg [NUM_LANES];

    logic               v_a_reg, v_b_reg;
    item_ctl_t          ctl_a_reg, ctl_b_reg;
    item_ctl_t          ctl_in;
    logic               rdy_a, rdy_b, go_a, take;
    lane_en_t           lane_en;
    axis_vec_t          axes;
    logic [4:0]         bcount;
    vel_t               lane_vel [NUM_LANES];

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadman_reg <= DEADMAN_RST;
            timeout_reg <= TIMEOUT_RST;
            map_reg[0]  <= X_MAP_RST;
            map_reg[1]  <= Y_MAP_RST;
            map_reg[2]  <= Z_MAP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DEADMAN: deadman_reg <= signed'(cfg_data[4:0]);
                REG_TIMEOUT: timeout_reg <= cfg_data[AGE_W-1:0];
                REG_X_MAP:   map_reg[0]  <= axis_map_t'(cfg_data);
                REG_Y_MAP:   map_reg[1]  <= axis_map_t'(cfg_data);
                REG_Z_MAP:   map_reg[2]  <= axis_map_t'(cfg_data);
                default:     ;
            endcase
        end
    end

    // deadman check on entry
    assign bcount = (req.button_count > 5'(BUTTON_LIMIT)) ? 5'(BUTTON_LIMIT)
                                                          : req.button_count;
    assign ctl_in.is_tick = req.cmd;
    assign ctl_in.held    = !deadman_reg[4]
                            && ({1'b0, deadman_reg[3:0]} < bcount)
                            && req.button_mask[deadman_reg[3:0]];

    assign axes = {req.axis_five, req.axis_four, req.axis_three,
                   req.axis_two, req.axis_one, req.axis_zero};

    // pipeline flow
    assign rdy_b  = !v_b_reg || take;
    assign rdy_a  = !v_a_reg || rdy_b;
    assign go_a   = v_a_reg && rdy_b;
    assign lane_en.load_a = req.valid && rdy_a;
    assign lane_en.load_b = go_a;
    assign req.ready = rdy_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg <= 1'b0;
            v_b_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                v_a_reg <= req.valid;
            end
            if (rdy_b)
            begin
                v_b_reg <= v_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (lane_en.load_a)
        begin
            ctl_a_reg <= ctl_in;
        end
        if (lane_en.load_b)
        begin
            ctl_b_reg <= ctl_a_reg;
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : lane_g
        jdvm_lane u_lane (
            .clk        (clk),
            .en         (lane_en),
            .axes       (axes),
            .axis_count (req.axis_count),
            .map        (map_reg[g]),
            .vel        (lane_vel[g])
        );
    end

    jdvm_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_b   (v_b_reg),
        .ctl_b     (ctl_b_reg),
        .lane_x    (lane_vel[0]),
        .lane_y    (lane_vel[1]),
        .lane_z    (lane_vel[2]),
        .timeout   (timeout_reg),
        .out_ready (rsp.ready),
        .take      (take),
        .out_valid (rsp.valid),
        .out_x     (rsp.vel_x),
        .out_y     (rsp.vel_y),
        .out_z     (rsp.vel_z),
        .out_stale (rsp.stale)
    );

    a_stale_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.stale |-> rsp.vel_x == '0 && rsp.vel_y == '0 && rsp.vel_z == '0)
        else $error("stale beat carries a nonzero command");

    a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> rsp.vel_x != 17'h10000 && rsp.vel_y != 17'h10000
                      && rsp.vel_z != 17'h10000)
        else $error("velocity beyond saturation limit");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_b_reg && !take |=> v_b_reg && $stable(ctl_b_reg))
        else $error("stalled merge entry lost");

endmodule

// ===== sim/tb_joystick_deadband_velocity_mapper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick deadband velocity mapper testbench
// Sends sample and tick beats on req and predicts the held velocity command
// and the stale flag of every tick. Each rsp beat is compared field by field
// with the oldest prediction. A directed table comes first. Randomised phases
// follow, each with its own register setting, most idling on either channel.
// A run of ticks at the end, with the timeout at its top, holds one sample.
// ----------------------------------------------------------------------------
module tb_joystick_deadband_velocity_mapper;
    import jdvm_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 190;
    localparam int AGE_RUN     = 60;
    localparam int SETTLE      = 8;
    localparam int MAX_REPORTS = 50;
    localparam int DIR_ROWS    = 22;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam longint unsigned MAG_MAX = (64'd1 << MAG_W) - 1;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  axis_count;
        axis_vec_t   axes;
        logic [15:0] mask;
        logic [4:0]  button_count;
    } joy_beat_t;

    typedef struct packed {
        vel_t x;
        vel_t y;
        vel_t z;
        logic stale;
    } vel_cmd_t;

    typedef struct packed {
        joy_beat_t beat;
        logic      typed;
        vel_cmd_t  want;
    } dir_row_t;

    localparam vel_cmd_t STILL      = '{17'sd0, 17'sd0, 17'sd0, 1'b0};
    localparam vel_cmd_t STILL_OLD  = '{17'sd0, 17'sd0, 17'sd0, 1'b1};

    localparam axis_t AXIS_EXTREMES [4] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF};

    // axes are listed from axis five down to axis zero
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{'{CMD_TICK, 3'd0, {6{16'h0000}}, 16'h0000, 5'd0}, 1'b1, STILL_OLD},
        '{'{CMD_TICK, 3'd7, {6{16'h7FFF}}, 16'hFFFF, 5'd31}, 1'b1, STILL_OLD},
        '{'{CMD_SAMPLE, 3'd6, {16'h1234, 16'hEDCB, 16'h0FFF, 16'h0000, 16'h8000, 16'h7FFF},
            16'h0001, 5'd16}, 1'b0, STILL},
        '{'{CMD_TICK, 3'd0, {6{16'h0000}}, 16'h0000, 5'd0}, 1'b0, STILL},
        '{'{CMD_SAMPLE, 3'd6, {16'h0001, 16'hFFFF, 16'h5555, 16'h8000, 16'h7FFF, 16'h8000},
            16'hFFFF, 5'd31}, 1'b0, STILL},
        '{'{CMD_TICK, 3'd7, {6{16'hFFFF}}, 16'hFFFF, 5'd31}, 1'b0, STILL},
        '{'{CMD_SAMPLE, 3'd6, {6{16'h8000}}, 16'hFFFE, 5'd16}, 1'b0, STILL},
        '{'{CMD_TICK, 3'd0, {6{16'h0000}}, 16'h0000, 5'd0}, 1'b1, STILL},
        '{'{CMD_SAMPLE, 3'd6, {6{16'h7FFF}}, 16'hFFFF, 5'd0}, 1'b0, STILL},
        '{'{CMD_TICK, 3'd0, {6{16'h0000}}, 16'h0000, 5'd0}, 1'b1, STILL},
        '{'{CMD_SAMPLE, 3'd0, {6{16'h8000}}, 16'h0001, 5'd1}, 1'b0, STILL},
        '{'{CMD_TICK, 3'd0, {6{16'h0000}}, 16'h0000, 5'd0}, 1'b1, STILL},
        '{'{CMD_SAMPLE, 3'd2, {16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 16'hF99B, 16'h0665},
            16'h0001, 5'd16}, 1'b0, STILL},
        '{'{CMD_TICK, 3'd0, {6{16'h0000}}, 16'h0000, 5'd0}, 1'b1, STILL},
        '{'{CMD_SAMPLE, 3'd3, {16'h0000, 16'h0000, 16'h0000, 16'h0667, 16'hF99A, 16'h0666},
            16'h0001, 5'd16}, 1'b0, STILL},
        '{'{CMD_TICK, 3'd0, {6{16'h0000}}, 16'h0000, 5'd0}, 1'b1, STILL},
        '{'{CMD_SAMPLE, 3'd7, {16'hAAAA, 16'h5555, 16'hFFFF, 16'h2000, 16'hC000, 16'h4000},
            16'h0001, 5'd16}, 1'b0, STILL},
        '{'{CMD_TICK, 3'd5, {6{16'h5A5A}}, 16'hA5A5, 5'd21}, 1'b0, STILL},
        '{'{CMD_TICK, 3'd2, {6{16'hA5A5}}, 16'h5A5A, 5'd10}, 1'b0, STILL},
        '{'{CMD_TICK, 3'd0, {6{16'h0000}}, 16'h0000, 5'd0}, 1'b0, STILL},
        '{'{CMD_SAMPLE, 3'd6, {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001},
            16'h0001, 5'd1}, 1'b0, STILL},
        '{'{CMD_TICK, 3'd0, {6{16'h0000}}, 16'h0000, 5'd0}, 1'b0, STILL}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    jdvm_req_if req_bus ();
    jdvm_rsp_if rsp_bus ();

    joystick_deadband_velocity_mapper i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copy and command state of the predictor
    logic signed [4:0] dm_index;
    logic [AGE_W-1:0]  fresh_limit;
    axis_map_t         lane_map [NUM_LANES];
    vel_t              held_vel [NUM_LANES];
    bit                sample_seen;
    logic [AGE_W-1:0]  ticks_since_sample;

    vel_cmd_t due_commands [$];
    int       send_idle_pct;
    int       stall_pct;
    bit       failed;
    int       reports;
    int       cycles;

    always #CLK_HALF clk = ~clk;

    function automatic vel_t lane_velocity(input axis_map_t map, input axis_vec_t axes,
                                           input logic [2:0] count);
        int                lim;
        int                a;
        int unsigned       m;
        int unsigned       db;
        longint unsigned   prod;
        int unsigned       mag;
        bit                neg;
        lim = (int'(count) < AXIS_LIMIT) ? int'(count) : AXIS_LIMIT;
        if (map.idx == AXIS_OFF || int'(map.idx) >= lim)
            return '0;
        a  = int'($signed(axes[map.idx]));
        m  = (a < 0) ? -a : a;
        db = int'(map.deadband);
        if (m < db)
            return '0;
        prod = longint'(m - db) * longint'(map.gain);
        prod = (prod + longint'(ROUND_BIAS)) >> FRAC_SHIFT;
        mag  = (prod > MAG_MAX) ? int'(MAG_MAX) : int'(prod);
        neg  = (a < 0) ^ map.inv;
        return neg ? -vel_t'(mag) : vel_t'(mag);
    endfunction

    function automatic bit advance_command(input joy_beat_t b, output vel_cmd_t r);
        int lim;
        bit held;
        bit stale;
        r = '0;
        if (b.cmd == CMD_SAMPLE) begin
            lim  = (int'(b.button_count) < BUTTON_LIMIT) ? int'(b.button_count) : BUTTON_LIMIT;
            held = (dm_index >= 0) && (int'(dm_index) < lim) && b.mask[dm_index[3:0]];
            sample_seen        = 1'b1;
            ticks_since_sample = '0;
            for (int k = 0; k < NUM_LANES; k++)
                held_vel[k] = held ? lane_velocity(lane_map[k], b.axes, b.axis_count) : '0;
            return 1'b0;
        end
        if (ticks_since_sample != AGE_MAX)
            ticks_since_sample++;
        stale = !sample_seen || (ticks_since_sample > fresh_limit);
        if (stale)
            held_vel = '{default: '0};
        r = '{held_vel[0], held_vel[1], held_vel[2], stale};
        return 1'b1;
    endfunction

    function automatic joy_beat_t sample_beat();
        joy_beat_t b;
        int        near_db;
        b.cmd        = CMD_SAMPLE;
        b.axis_count = ($urandom_range(9) < 8) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(7));
        for (int k = 0; k < AXIS_FIELDS; k++) begin
            case ($urandom_range(3))
                0: b.axes[k] = 16'($urandom);
                1: b.axes[k] = AXIS_EXTREMES[$urandom_range(3)];
                2: begin
                    near_db = int'(lane_map[$urandom_range(NUM_LANES - 1)].deadband)
                              + int'($urandom_range(2)) - 1;
                    b.axes[k] = $urandom_range(1) ? 16'(near_db) : 16'(-near_db);
                end
                default: b.axes[k] = 16'(int'($urandom_range(24000)) - 12000);
            endcase
        end
        b.mask = 16'($urandom);
        if (dm_index >= 0 && $urandom_range(99) < 85)
            b.mask[dm_index[3:0]] = 1'b1;
        b.button_count = ($urandom_range(3) != 0) ? 5'($urandom_range(31, 16))
                                                  : 5'($urandom_range(31));
        return b;
    endfunction

    function automatic joy_beat_t tick_beat();
        joy_beat_t b;
        b.cmd        = CMD_TICK;
        b.axis_count = 3'($urandom);
        for (int k = 0; k < AXIS_FIELDS; k++)
            b.axes[k] = 16'($urandom);
        b.mask         = 16'($urandom);
        b.button_count = 5'($urandom);
        return b;
    endfunction

    function automatic axis_map_t rand_map();
        axis_map_t mp;
        mp.idx = ($urandom_range(9) < 7) ? 4'($urandom_range(5)) : 4'($urandom_range(15));
        mp.inv = 1'($urandom);
        case ($urandom_range(3))
            0:       mp.deadband = '0;
            1:       mp.deadband = '1;
            default: mp.deadband = 15'($urandom_range(4000));
        endcase
        case ($urandom_range(3))
            0:       mp.gain = '1;
            1:       mp.gain = 16'($urandom_range(64));
            default: mp.gain = 16'($urandom_range(1024));
        endcase
        return mp;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            failed = 1'b1;
            if (reports < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            reports++;
        end
    endtask

    task automatic drive_beat(input joy_beat_t b, input bit typed, input vel_cmd_t want);
        vel_cmd_t predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.cmd          <= b.cmd;
        req_bus.axis_count   <= b.axis_count;
        req_bus.axis_zero    <= b.axes[0];
        req_bus.axis_one     <= b.axes[1];
        req_bus.axis_two     <= b.axes[2];
        req_bus.axis_three   <= b.axes[3];
        req_bus.axis_four    <= b.axes[4];
        req_bus.axis_five    <= b.axes[5];
        req_bus.button_mask  <= b.mask;
        req_bus.button_count <= b.button_count;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        if (advance_command(b, predicted))
            due_commands.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_bus.valid <= 1'b0;
        while (due_commands.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (index)
            REG_DEADMAN: dm_index    = data[4:0];
            REG_TIMEOUT: fresh_limit = data[AGE_W-1:0];
            REG_X_MAP:   lane_map[0] = axis_map_t'(data);
            REG_Y_MAP:   lane_map[1] = axis_map_t'(data);
            REG_Z_MAP:   lane_map[2] = axis_map_t'(data);
            default: ;
        endcase
    endtask

    task automatic configure_phase(input int ph);
        logic [CFG_DATA_W-1:0] noise;
        int                    dm;
        int                    limit;
        axis_map_t             maps [NUM_LANES];
        noise = CFG_DATA_W'({$urandom, $urandom});
        case (ph)
            0: begin
                dm      = 3;
                limit   = 50;
                maps[0] = '{gain: 16'hFFFF, deadband: 15'd0, inv: 1'b1, idx: 4'd3};
                maps[1] = '{gain: 16'h0100, deadband: 15'h7FFF, inv: 1'b0, idx: 4'd5};
                maps[2] = '{gain: 16'h1234, deadband: 15'd500, inv: 1'b1, idx: AXIS_OFF};
                for (int i = int'(REG_Z_MAP) + 1; i < (1 << CFG_IDX_W); i++)
                    write_reg(CFG_IDX_W'(i), CFG_DATA_W'({$urandom, $urandom}));
            end
            1: begin
                dm      = 15;
                limit   = 0;
                maps[0] = '{gain: 16'h0000, deadband: 15'd1000, inv: 1'b0, idx: 4'd0};
                maps[1] = '{gain: 16'h0200, deadband: 15'd100, inv: 1'b1, idx: 4'd4};
                maps[2] = '{gain: 16'h0180, deadband: 15'd2000, inv: 1'b0, idx: 4'd7};
            end
            2: begin
                dm    = -1;
                limit = int'(AGE_MAX);
                foreach (maps[k]) maps[k] = rand_map();
            end
            3: begin
                dm    = int'($urandom_range(15));
                limit = 3;
                foreach (maps[k]) maps[k] = rand_map();
            end
            default: begin
                dm = ($urandom_range(4) == 0) ? int'($urandom_range(31))
                                              : int'($urandom_range(16)) - 1;
                case ($urandom_range(4))
                    0:       limit = 0;
                    1:       limit = 1;
                    2:       limit = 50;
                    3:       limit = int'(AGE_MAX);
                    default: limit = int'($urandom_range(120));
                endcase
                foreach (maps[k]) maps[k] = rand_map();
            end
        endcase
        write_reg(REG_DEADMAN, {noise[CFG_DATA_W-1:5], 5'(dm)});
        write_reg(REG_TIMEOUT, {noise[CFG_DATA_W-1:AGE_W], AGE_W'(limit)});
        for (int k = 0; k < NUM_LANES; k++)
            write_reg(CFG_IDX_W'(int'(REG_X_MAP) + k), CFG_DATA_W'(maps[k]));
    endtask

    task automatic random_beats(input int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 4) begin
                // run the age past the timeout, or stop just short of it
                if (fresh_limit < 16'd100)
                    burst = int'($urandom_range(int'(fresh_limit) + 3,
                                 (fresh_limit > 16'd2) ? int'(fresh_limit) - 2 : 1));
                else
                    burst = int'($urandom_range(20, 1));
                repeat (burst) drive_beat(tick_beat(), 1'b0, STILL);
                sent += burst;
            end else if ($urandom_range(99) == 0) begin
                wait_drained();
            end else begin
                drive_beat($urandom_range(1) ? tick_beat() : sample_beat(), 1'b0, STILL);
                sent++;
            end
        end
    endtask

    always @(posedge clk) begin : rsp_check
        vel_cmd_t want;
        if (rsp_bus.valid && rsp_bus.ready) begin
            if (due_commands.size() == 0) begin
                failed = 1'b1;
                if (reports < MAX_REPORTS)
                    $display("%0t: unexpected beat, expected none, got x %0d y %0d z %0d stale %0b",
                             $time, rsp_bus.vel_x, rsp_bus.vel_y, rsp_bus.vel_z, rsp_bus.stale);
                reports++;
            end else begin
                want = due_commands.pop_front();
                check_field("vel_x", want.x, rsp_bus.vel_x);
                check_field("vel_y", want.y, rsp_bus.vel_y);
                check_field("vel_z", want.z, rsp_bus.vel_z);
                check_field("stale", want.stale, rsp_bus.stale);
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(negedge clk);
            rsp_bus.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        joy_beat_t first_sample;
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= '0;
        cfg_data             <= '0;
        req_bus.valid        <= 1'b0;
        req_bus.cmd          <= CMD_SAMPLE;
        req_bus.axis_count   <= '0;
        req_bus.axis_zero    <= '0;
        req_bus.axis_one     <= '0;
        req_bus.axis_two     <= '0;
        req_bus.axis_three   <= '0;
        req_bus.axis_four    <= '0;
        req_bus.axis_five    <= '0;
        req_bus.button_mask  <= '0;
        req_bus.button_count <= '0;
        send_idle_pct      = 0;
        stall_pct          = 0;
        failed             = 1'b0;
        reports            = 0;
        cycles             = 0;
        dm_index           = DEADMAN_RST;
        fresh_limit        = TIMEOUT_RST;
        lane_map           = '{X_MAP_RST, Y_MAP_RST, Z_MAP_RST};
        held_vel           = '{default: '0};
        sample_seen        = 1'b0;
        ticks_since_sample = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            drive_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            configure_phase(ph);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 68; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 68; end
                default: begin send_idle_pct = 10; stall_pct = 10; end
            endcase
            random_beats(PHASE_BEATS);
        end

        // hold one sample, then tick past the default timeout with the limit at its top
        send_idle_pct = 0;
        stall_pct     = 0;
        wait_drained();
        write_reg(REG_DEADMAN, CFG_DATA_W'(DEADMAN_RST));
        write_reg(REG_TIMEOUT, CFG_DATA_W'(AGE_MAX));
        write_reg(REG_X_MAP, CFG_DATA_W'(X_MAP_RST));
        write_reg(REG_Y_MAP, CFG_DATA_W'(Y_MAP_RST));
        write_reg(REG_Z_MAP, CFG_DATA_W'(Z_MAP_RST));
        first_sample                 = sample_beat();
        first_sample.mask[0]         = 1'b1;
        first_sample.button_count    = 5'd16;
        drive_beat(first_sample, 1'b0, STILL);
        repeat (AGE_RUN) drive_beat(tick_beat(), 1'b0, STILL);
        wait_drained();
        write_reg(REG_TIMEOUT, CFG_DATA_W'(AGE_MAX - 1'b1));
        drive_beat(tick_beat(), 1'b0, STILL);
        wait_drained();
        write_reg(REG_TIMEOUT, CFG_DATA_W'(AGE_MAX));
        drive_beat(tick_beat(), 1'b0, STILL);
        wait_drained();

        if (!failed)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
